// File: design/hrd_pkg.sv
// hrd_pkg: shared types and constants for the HTTP response deframer.
// No dependencies.
package hrd_pkg;

   localparam int NameBits = 5;

   typedef enum logic [3:0] {
      KIND_VERSION     = 4'd0,
      KIND_CODE        = 4'd1,
      KIND_PHRASE      = 4'd2,
      KIND_STATUS_END  = 4'd3,
      KIND_NAME        = 4'd4,
      KIND_VALUE       = 4'd5,
      KIND_HEADER_END  = 4'd6,
      KIND_HEADERS_DONE= 4'd7,
      KIND_BODY        = 4'd8,
      KIND_BODY_END    = 4'd9,
      KIND_ERROR       = 4'd10
   } kind_type;

   localparam logic [1:0] ERR_STATUS     = 2'd0;
   localparam logic [1:0] ERR_NO_COLON   = 2'd1;
   localparam logic [1:0] ERR_CHUNK_LINE = 2'd2;
   localparam logic [1:0] ERR_CHUNK_CRLF = 2'd3;

   typedef enum logic [7:0] {
      PH_STATUS      = 8'b0000_0001,
      PH_PHRASE      = 8'b0000_0010,
      PH_HEADERS     = 8'b0000_0100,
      PH_CHECK       = 8'b0000_1000,
      PH_CHUNK_START = 8'b0001_0000,
      PH_BODY        = 8'b0010_0000,
      PH_CHUNK_END   = 8'b0100_0000,
      PH_COMPLETE    = 8'b1000_0000
   } phase_type;

   localparam logic [1:0] BODY_NONE    = 2'd0;
   localparam logic [1:0] BODY_COUNTED = 2'd1;
   localparam logic [1:0] BODY_CHUNKED = 2'd2;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] data;
      logic       no_body;
      logic       body_final;
      logic [1:0] err_code;
   } rsp_item_type;

   // group of up to three result slots for one byte
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type r0;
      rsp_item_type r1;
      rsp_item_type r2;
   } group_type;

   function automatic logic [7:0] te_char(input logic [4:0] i);
      case (i)
         5'd0: te_char = "t";  5'd1: te_char = "r";  5'd2: te_char = "a";
         5'd3: te_char = "n";  5'd4: te_char = "s";  5'd5: te_char = "f";
         5'd6: te_char = "e";  5'd7: te_char = "r";  5'd8: te_char = "-";
         5'd9: te_char = "e";  5'd10: te_char = "n"; 5'd11: te_char = "c";
         5'd12: te_char = "o"; 5'd13: te_char = "d"; 5'd14: te_char = "i";
         5'd15: te_char = "n"; 5'd16: te_char = "g";
         default: te_char = 8'd0;
      endcase
   endfunction

   function automatic logic [7:0] cl_char(input logic [4:0] i);
      case (i)
         5'd0: cl_char = "c";  5'd1: cl_char = "o";  5'd2: cl_char = "n";
         5'd3: cl_char = "t";  5'd4: cl_char = "e";  5'd5: cl_char = "n";
         5'd6: cl_char = "t";  5'd7: cl_char = "-";  5'd8: cl_char = "l";
         5'd9: cl_char = "e";  5'd10: cl_char = "n"; 5'd11: cl_char = "g";
         5'd12: cl_char = "t"; 5'd13: cl_char = "h";
         default: cl_char = 8'd0;
      endcase
   endfunction

   function automatic logic [7:0] ck_char(input logic [3:0] i);
      case (i)
         4'd0: ck_char = "c"; 4'd1: ck_char = "h"; 4'd2: ck_char = "u";
         4'd3: ck_char = "n"; 4'd4: ck_char = "k"; 4'd5: ck_char = "e";
         4'd6: ck_char = "d";
         default: ck_char = 8'd0;
      endcase
   endfunction

endpackage

// File: design/hrd_if.sv
// hrd_if: valid/ready channel interfaces for the deframer.
// Depends on nothing.
interface hrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface hrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] out_kind;
   logic [7:0] out_byte;
   logic       no_body;
   logic       body_final;
   logic [1:0] err_code;
   logic       last;
   modport source (output valid, output out_kind, output out_byte, output no_body,
                   output body_final, output err_code, output last, input ready);
   modport sink   (input valid, input out_kind, input out_byte, input no_body,
                   input body_final, input err_code, input last, output ready);
endinterface

// File: design/http_response_deframer.sv
// http_response_deframer: top level, byte-serial HTTP/1.x response deframer.
// Depends on hrd_pkg, hrd_if, hrd_front, hrd_back.
// One response byte is taken per cycle whenever the four-group result queue
// holds fewer than four groups; each byte yields zero to two results, which are
// registered as a group in the queue and delivered from its head one per
// cycle while rsp.ready is high, with last marking the final result of a byte.
// Throughput is one byte per cycle while the sink keeps up; the result port,
// at one result a cycle, sets the limit when bytes produce several results.
module http_response_deframer import hrd_pkg::*; #(
   parameter int LENGTH_BITS = 64,
   parameter int CHUNK_BITS  = 31
) (
   input  logic    clock,
   input  logic    reset,
   hrd_req_if.sink   req,
   hrd_rsp_if.source rsp
);
   group_type grp;
   logic      grp_valid, can_take;

   assign req.ready = can_take;

   hrd_front #(.LENGTH_BITS(LENGTH_BITS), .CHUNK_BITS(CHUNK_BITS)) u_front (
      .clock(clock), .reset(reset), .byte_valid(req.valid && req.ready),
      .in_byte(req.in_byte), .grp(grp), .grp_valid(grp_valid));

   hrd_back u_back (
      .clock(clock), .reset(reset), .grp_valid(grp_valid), .grp(grp),
      .can_take(can_take), .rsp(rsp));
endmodule

// File: design/hrd_front.sv
// hrd_front: parser state machine; classifies each byte into a result group.
// Depends on hrd_pkg.
module hrd_front import hrd_pkg::*; #(
   parameter int LENGTH_BITS = 64,
   parameter int CHUNK_BITS  = 31
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      byte_valid,
   input  logic [7:0] in_byte,
   output group_type grp,
   output logic      grp_valid
);
   localparam int HB = (CHUNK_BITS < LENGTH_BITS) ? CHUNK_BITS : LENGTH_BITS;

   phase_type             phase_ff, phase_in;
   logic [1:0]            spart_ff, spart_in, bkind_ff, bkind_in, hpart_ff, hpart_in;
   logic [1:0]            nmatch_ff, nmatch_in, dok_ff, dok_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in, dacc_ff, dacc_in;
   logic [HB-1:0]         hacc_ff, hacc_in;
   logic [2:0]            hstat_ff, hstat_in;
   logic                  cr_ff, cr_in, nonempty_ff, nonempty_in, failed_ff, failed_in;
   logic [NameBits-1:0]   npos_ff, npos_in;
   logic [3:0]            cpos_ff, cpos_in;
   group_type             g;

   function automatic rsp_item_type mk(input kind_type k, input logic [7:0] d,
                                       input logic nb, input logic fin,
                                       input logic [1:0] e);
      rsp_item_type r;
      r.kind = k; r.data = d; r.no_body = nb; r.body_final = fin; r.err_code = e;
      return r;
   endfunction

   always_comb begin
      logic [7:0] b, lc, c;
      logic       do_end, do_content, do_cr, stop;
      logic [3:0] dig;
      logic       isdig;
      logic [LENGTH_BITS+3:0] dprod;
      logic [HB+4:0] hprod;
      rsp_item_type it;
      logic emitc;
      logic [1:0] hp;
      logic [NameBits-1:0] np;
      logic [1:0] nm;
      phase_in = phase_ff; spart_in = spart_ff; bkind_in = bkind_ff; hpart_in = hpart_ff;
      nmatch_in = nmatch_ff; dok_in = dok_ff; left_in = left_ff; dacc_in = dacc_ff;
      hacc_in = hacc_ff; hstat_in = hstat_ff; cr_in = cr_ff; nonempty_in = nonempty_ff;
      failed_in = failed_ff; npos_in = npos_ff; cpos_in = cpos_ff;
      g = '0;
      b = in_byte; stop = 1'b0; do_end = 1'b0; do_content = 1'b0; do_cr = 1'b0; c = b;
      dig = 4'd0; isdig = 1'b0; lc = 8'd0; dprod = '0; hprod = '0;
      it = '0; emitc = 1'b0; hp = '0; np = '0; nm = '0;
      if (!failed_ff && phase_ff != PH_COMPLETE) begin
         case (phase_ff)
            PH_CHECK: begin
               if (b == " " || b == 8'h09) begin
                  phase_in = PH_HEADERS; do_content = 1'b1;
               end else if (hpart_ff == 2'd0) begin
                  failed_in = 1'b1;
                  g.r0 = mk(KIND_ERROR, 8'd0, 1'b0, 1'b0, ERR_NO_COLON); g.count = 2'd1;
                  stop = 1'b1;
               end else begin
                  if (nmatch_ff[0] && npos_ff == 5'd17) begin
                     if (cpos_ff == 4'd7) bkind_in = BODY_CHUNKED;
                  end else if (bkind_ff != BODY_CHUNKED && nmatch_ff[1] && npos_ff == 5'd14)
                  begin
                     if (dok_ff == 2'd1 && dacc_ff != '0) begin
                        left_in = dacc_ff; bkind_in = BODY_COUNTED;
                     end
                  end
                  g.r0 = mk(KIND_HEADER_END, 8'd0, 1'b0, 1'b0, 2'd0); g.count = 2'd1;
                  hpart_in = 2'd0; npos_in = '0; nmatch_in = 2'd3; cpos_in = '0;
                  dacc_in = '0; dok_in = '0; nonempty_in = 1'b0;
                  phase_in = PH_HEADERS;
                  if (b == 8'h0d) cr_in = 1'b1; else do_content = 1'b1;
               end
            end
            PH_BODY: begin
               if (left_ff <= 1) begin
                  left_in = '0;
                  if (bkind_ff == BODY_CHUNKED) begin
                     phase_in = PH_CHUNK_END;
                     g.r0 = mk(KIND_BODY, b, 1'b0, 1'b0, 2'd0);
                  end else begin
                     phase_in = PH_COMPLETE;
                     g.r0 = mk(KIND_BODY, b, 1'b0, 1'b1, 2'd0);
                  end
               end else begin
                  left_in = left_ff - 1'b1;
                  g.r0 = mk(KIND_BODY, b, 1'b0, 1'b0, 2'd0);
               end
               g.count = 2'd1;
            end
            PH_CHUNK_END: begin
               if (!cr_ff) begin
                  if (b == 8'h0d) cr_in = 1'b1;
                  else begin
                     failed_in = 1'b1; g.count = 2'd1;
                     g.r0 = mk(KIND_ERROR, 8'd0, 1'b0, 1'b0, ERR_CHUNK_CRLF);
                  end
               end else begin
                  cr_in = 1'b0;
                  if (b == 8'h0a) phase_in = PH_CHUNK_START;
                  else begin
                     failed_in = 1'b1; g.count = 2'd1;
                     g.r0 = mk(KIND_ERROR, 8'd0, 1'b0, 1'b0, ERR_CHUNK_CRLF);
                  end
               end
            end
            default: begin
               // line-oriented phases; a held CR not followed by LF is content
               if (cr_ff) begin
                  cr_in = 1'b0;
                  if (b == 8'h0a) do_end = 1'b1;
                  else begin
                     do_cr = 1'b1;
                     if (b == 8'h0d) cr_in = 1'b1;
                     else do_content = 1'b1;
                  end
               end else if (b == 8'h0d) cr_in = 1'b1;
               else do_content = 1'b1;
            end
         endcase

         if (do_end) begin
            if (phase_ff == PH_STATUS || phase_ff == PH_PHRASE) begin
               if (phase_ff == PH_STATUS && spart_ff < 2'd2) begin
                  failed_in = 1'b1; g.count = 2'd1;
                  g.r0 = mk(KIND_ERROR, 8'd0, 1'b0, 1'b0, ERR_STATUS);
               end else begin
                  g.count = 2'd1;
                  g.r0 = mk(KIND_STATUS_END, 8'd0, 1'b0, 1'b0, 2'd0);
                  phase_in = PH_HEADERS;
                  hpart_in = 2'd0; npos_in = '0; nmatch_in = 2'd3; cpos_in = '0;
                  dacc_in = '0; dok_in = '0; nonempty_in = 1'b0;
               end
            end else if (phase_ff == PH_HEADERS) begin
               if (nonempty_ff) phase_in = PH_CHECK;
               else begin
                  if (bkind_ff == BODY_CHUNKED) phase_in = PH_CHUNK_START;
                  else if (bkind_ff == BODY_COUNTED) phase_in = PH_BODY;
                  else phase_in = PH_COMPLETE;
                  g.count = 2'd1;
                  g.r0 = mk(KIND_HEADERS_DONE, 8'd0, bkind_ff == BODY_NONE, 1'b0, 2'd0);
               end
            end else begin
               if (!hstat_ff[0] || hstat_ff[2]) begin
                  failed_in = 1'b1; g.count = 2'd1;
                  g.r0 = mk(KIND_ERROR, 8'd0, 1'b0, 1'b0, ERR_CHUNK_LINE);
               end else begin
                  left_in = LENGTH_BITS'(hacc_ff); hacc_in = '0; hstat_in = '0;
                  if (hacc_ff == '0) begin
                     phase_in = PH_COMPLETE; g.count = 2'd1;
                     g.r0 = mk(KIND_BODY_END, 8'd0, 1'b0, 1'b1, 2'd0);
                  end else phase_in = PH_BODY;
               end
            end
         end

         // pass 0 handles a held CR, pass 1 the current byte
         for (int k = 0; k < 2; k++) begin
            if ((k == 0) ? do_cr : (do_content && !stop)) begin
               c = (k == 0) ? 8'h0d : b;
               it = '0; emitc = 1'b0; isdig = 1'b0; dig = 4'd0;
               if (phase_in == PH_STATUS || phase_in == PH_PHRASE) begin
                  if (phase_in == PH_PHRASE) begin
                     emitc = 1'b1; it = mk(KIND_PHRASE, c, 1'b0, 1'b0, 2'd0);
                  end else begin
                     case (spart_in)
                        2'd0: if (c == " ") spart_in = 2'd1;
                              else begin
                                 emitc = 1'b1; it = mk(KIND_VERSION, c, 1'b0, 1'b0, 2'd0);
                              end
                        2'd1: if (c != " ") begin
                                 spart_in = 2'd2; emitc = 1'b1;
                                 it = mk(KIND_CODE, c, 1'b0, 1'b0, 2'd0);
                              end
                        2'd2: if (c == " ") spart_in = 2'd3;
                              else begin
                                 emitc = 1'b1; it = mk(KIND_CODE, c, 1'b0, 1'b0, 2'd0);
                              end
                        default: if (c != " ") begin
                                 phase_in = PH_PHRASE; emitc = 1'b1;
                                 it = mk(KIND_PHRASE, c, 1'b0, 1'b0, 2'd0);
                              end
                     endcase
                  end
               end else if (phase_in == PH_HEADERS) begin
                  hp = hpart_in; np = npos_in; nm = nmatch_in;
                  nonempty_in = 1'b1;
                  if (hp == 2'd0) begin
                     if (c == ":") hpart_in = 2'd1;
                     else begin
                        emitc = 1'b1; it = mk(KIND_NAME, c, 1'b0, 1'b0, 2'd0);
                        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                        if (np >= 5'd17 || lc != te_char(np)) nm[0] = 1'b0;
                        if (np >= 5'd14 || lc != cl_char(np)) nm[1] = 1'b0;
                        nmatch_in = nm;
                        if (np < 5'd31) npos_in = np + 1'b1;
                     end
                  end else if (!(hp == 2'd1 && (c == " " || c == 8'h09))) begin
                     hpart_in = 2'd2;
                     emitc = 1'b1; it = mk(KIND_VALUE, c, 1'b0, 1'b0, 2'd0);
                     if (cpos_in < 4'd7 && c == ck_char(cpos_in)) cpos_in = cpos_in + 1'b1;
                     else cpos_in = 4'd15;
                     isdig = (c >= "0" && c <= "9");
                     dig = c[3:0];
                     if (isdig && !dok_in[1]) begin
                        dprod = ({4'd0, dacc_in} << 3) + ({4'd0, dacc_in} << 1)
                              + {{LENGTH_BITS{1'b0}}, dig};
                        if (dprod[LENGTH_BITS+3:LENGTH_BITS] != '0) dok_in[1] = 1'b1;
                        else begin
                           dacc_in = dprod[LENGTH_BITS-1:0]; dok_in[0] = 1'b1;
                        end
                     end else dok_in[1] = 1'b1;
                  end
               end else begin
                  if (!hstat_in[1]) begin
                     if (c >= "0" && c <= "9") begin isdig = 1'b1; dig = c[3:0]; end
                     else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
                        isdig = 1'b1; dig = c[3:0] + 4'd9;
                     end
                     if (!isdig) hstat_in[1] = 1'b1;
                     else begin
                        hstat_in[0] = 1'b1;
                        if (!hstat_in[2]) begin
                           hprod = {hacc_in, 4'd0} + {{HB{1'b0}}, 1'b0, dig};
                           if (hprod[HB+4:HB] != '0) hstat_in[2] = 1'b1;
                           else hacc_in = hprod[HB-1:0];
                        end
                     end
                  end
               end
               if (emitc) begin
                  if (g.count == 2'd0) g.r0 = it; else g.r1 = it;
                  g.count = g.count + 2'd1;
               end
            end
         end
      end
      grp = g;
      grp_valid = byte_valid && (g.count != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STATUS; spart_ff <= '0; bkind_ff <= BODY_NONE; left_ff <= '0;
         cr_ff <= 1'b0; nonempty_ff <= 1'b0; hpart_ff <= '0; npos_ff <= '0;
         nmatch_ff <= 2'd3; cpos_ff <= '0; dacc_ff <= '0; dok_ff <= '0;
         hacc_ff <= '0; hstat_ff <= '0; failed_ff <= 1'b0;
      end else if (byte_valid) begin
         phase_ff <= phase_in; spart_ff <= spart_in; bkind_ff <= bkind_in;
         left_ff <= left_in; cr_ff <= cr_in; nonempty_ff <= nonempty_in;
         hpart_ff <= hpart_in; npos_ff <= npos_in; nmatch_ff <= nmatch_in;
         cpos_ff <= cpos_in; dacc_ff <= dacc_in; dok_ff <= dok_in;
         hacc_ff <= hacc_in; hstat_ff <= hstat_in; failed_ff <= failed_in;
      end
   end

   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff |=> failed_ff) else $error("fail flag cleared");
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (failed_ff || phase_ff == PH_COMPLETE) |-> !grp_valid)
      else $error("result after completion");
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff)) else $error("phase not one-hot");
endmodule

// File: design/hrd_back.sv
// hrd_back: group queue and result serializer.
// Depends on hrd_pkg and hrd_if.
module hrd_back import hrd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      grp_valid,
   input  group_type grp,
   output logic      can_take,
   hrd_rsp_if.source rsp
);
   group_type  q_ff [4];
   logic [1:0] wp_ff, rp_ff, idx_ff;
   logic [2:0] cnt_ff;
   logic       pop;
   group_type  h;
   rsp_item_type it;

   assign can_take = cnt_ff != 3'd4;
   assign h = q_ff[rp_ff];
   always_comb begin
      case (idx_ff)
         2'd0: it = h.r0;
         2'd1: it = h.r1;
         default: it = h.r2;
      endcase
   end
   assign rsp.valid = cnt_ff != 3'd0;
   assign rsp.out_kind = it.kind;
   assign rsp.out_byte = it.data;
   assign rsp.no_body = it.no_body;
   assign rsp.body_final = it.body_final;
   assign rsp.err_code = it.err_code;
   assign rsp.last = (idx_ff + 2'd1) == h.count;
   assign pop = rsp.valid && rsp.ready && rsp.last;

   always_ff @(posedge clock) begin
      if (grp_valid) q_ff[wp_ff] <= grp;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; idx_ff <= '0; cnt_ff <= '0;
      end else begin
         if (grp_valid) wp_ff <= wp_ff + 2'd1;
         if (rsp.valid && rsp.ready) begin
            if (rsp.last) begin
               idx_ff <= '0; rp_ff <= rp_ff + 2'd1;
            end else idx_ff <= idx_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + {2'd0, grp_valid} - {2'd0, pop};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4) else $error("queue overflow");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> idx_ff < h.count) else $error("index past group");
   a_empty_idle: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 3'd0 |-> idx_ff == 2'd0) else $error("index on empty queue");
endmodule
